### rtl/core/drhu_pkg.sv
`default_nettype none
package drhu_pkg;

  localparam int unsigned WordW    = 64;
  localparam int unsigned FracW    = 52;
  localparam int unsigned ExpW     = 11;
  localparam int unsigned ShiftW   = 6;
  localparam logic [ExpW-1:0] ExpAllOnes = 11'h7FF;
  localparam logic [ExpW-1:0] ExpHalf    = 11'd1022;
  localparam logic [ExpW-1:0] ExpIntegral = 11'd1075;
  localparam logic [ExpW-1:0] ExpBias    = 11'd1023;

  // Classification of an operand
  typedef enum logic [1:0] {
    CLS_PASS  = 2'd0,
    CLS_ZERO  = 2'd1,
    CLS_ROUND = 2'd2
  } cls_t;

  // Stage-one result handed to the encoder
  typedef struct packed {
    cls_t            cls;
    logic            sign;
    logic [WordW-1:0] raw;
    logic [53:0]     n;
  } mid_t;

endpackage
`default_nettype wire

### rtl/core/double_round_half_up.sv
`default_nettype none
// Rounds a binary64 operand to an integer with ties toward +infinity
// (NaN, infinities, zeros and magnitudes of 2^52 or more pass unchanged).
// A request accepted at a clock edge is loaded into the input register,
// classify/round and re-normalize run combinationally from that register,
// and the result is loaded into the output register, where out_valid rises.
// One request is accepted every cycle while the output is not stalled;
// throughput is set by the two pipeline registers, each of which advances
// whenever the stage ahead is free.
module double_round_half_up (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [63:0] in_value_bits,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_result_bits
);
  import drhu_pkg::*;

  logic        s1_valid_r;
  logic [63:0] s1_bits_r;
  logic        s1_adv;
  mid_t        mid;
  logic [63:0] res;
  logic [63:0] out_bits_r;
  logic        out_valid_r;

  assign s1_adv   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_adv;

  drhu_round u_round (.value_bits(s1_bits_r), .mid(mid));
  drhu_encode u_encode (.mid(mid), .result_bits(res));

  // input stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
    if (in_ready && in_valid) s1_bits_r <= in_value_bits;
  end

  // result stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!out_valid_r || out_ready) begin
      out_valid_r <= s1_valid_r;
    end
    if (s1_adv) out_bits_r <= res;
  end

  assign out_valid       = out_valid_r;
  assign out_result_bits = out_bits_r;

endmodule
`default_nettype wire

### rtl/core/drhu_round.sv
`default_nettype none
// Classify the operand and compute the integer magnitude floor(|x| rounded)
module drhu_round (
  input  logic [63:0]    value_bits,
  output drhu_pkg::mid_t mid
);
  import drhu_pkg::*;

  logic [ExpW-1:0]  exp;
  logic [FracW-1:0] frac;
  logic [53:0]      m;
  logic [ShiftW-1:0] s;
  logic [53:0]      half;
  logic [53:0]      lowmask;
  logic [53:0]      sum;

  always_comb begin
    exp     = value_bits[62:52];
    frac    = value_bits[51:0];
    m       = {2'b01, frac};
    s       = ShiftW'(ExpIntegral - exp);
    half    = 54'd1 << (s - ShiftW'(1));
    lowmask = (54'd1 << s) - 54'd1;
    // positive: m+half, negative: m-half+(2^s-1) = m + (half-1)
    sum = value_bits[63] ? (m + half - 54'd1) : (m + half);
    mid.raw  = value_bits;
    mid.sign = value_bits[63];
    mid.n    = (sum & ~lowmask) >> s;
    if (exp == ExpAllOnes || (exp == '0 && frac == '0) || exp >= ExpIntegral) begin
      mid.cls = CLS_PASS;
    end else if (exp < ExpHalf || (value_bits[63] && exp == ExpHalf && frac == '0)) begin
      mid.cls = CLS_ZERO;
    end else begin
      mid.cls = CLS_ROUND;
    end
  end

endmodule
`default_nettype wire

### rtl/core/drhu_encode.sv
`default_nettype none
// Normalize the integer magnitude back into binary64
module drhu_encode (
  input  drhu_pkg::mid_t mid,
  output logic [63:0]    result_bits
);
  import drhu_pkg::*;

  logic [ShiftW-1:0] p;
  logic [53:0]       norm;

  // leading-one position; for CLS_ROUND n is nonzero and at most 2^52
  always_comb begin
    p = '0;
    for (int i = 0; i < 54; i++) begin
      if (mid.n[i]) p = ShiftW'(i);
    end
    norm = mid.n << (ShiftW'(52) - p);
    unique case (mid.cls)
      CLS_PASS:  result_bits = mid.raw;
      CLS_ZERO:  result_bits = {mid.sign, 63'd0};
      CLS_ROUND: result_bits = {mid.sign, ExpBias + ExpW'(p), norm[51:0]};
      default:   result_bits = mid.raw;
    endcase
  end

endmodule
`default_nettype wire

### rtl/core/drhu_checker.sv
`default_nettype none
// Port-level checks of the rounding unit
module drhu_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic [63:0] in_value_bits,
  input logic        out_valid,
  input logic        out_ready,
  input logic [63:0] out_result_bits
);
  // no result appears without an earlier request
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready, 2) || $past(in_valid && in_ready, 1) ||
    $past(out_valid))
    else $error("result without request");

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_result_bits))
    else $error("stalled result changed");

  // a free pipeline always takes a request
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("not ready while empty output");

  // a request taken while the output is empty gives a result via the input and output registers
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !out_valid |=> ##1 out_valid)
    else $error("missing result");
endmodule

bind double_round_half_up drhu_checker u_drhu_checker (.*);
`default_nettype wire
